// ----- sv/bmu_pkg.sv -----
`default_nettype none
package bmu_pkg;

    // table geometry and field widths
    localparam int ENTRIES   = 16;
    localparam int LINE_BITS = 24;
    localparam int ID_W      = 16;
    localparam int FILE_W    = 16;
    localparam int CNT_W     = 16;
    localparam int LINE_IN_W = 24;

    // item opcodes
    localparam logic [1:0] OP_TRACE = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_DEL   = 2'd2;
    localparam logic [1:0] OP_STEP  = 2'd3;

    // trace event kinds
    localparam logic [1:0] EV_STMT = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN   = 2'd2;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    // token that walks the row of cells, one cell a cycle
    typedef struct packed {
        logic            vld;
        logic            done;
        logic [ID_W-1:0] best;
    } t_token;

    // item held steady for the whole scan
    typedef struct packed {
        logic [1:0]           op;
        logic [FILE_W-1:0]    file;
        logic [LINE_BITS-1:0] line;
        logic [ID_W-1:0]      target;
        logic [CNT_W-1:0]     ign;
        logic                 tmp;
        logic [ID_W-1:0]      new_id;
    } t_cmd;

    // counter update broadcast after a trace scan
    typedef struct packed {
        logic            vld;
        logic            found;
        logic [ID_W-1:0] fire;
    } t_apply;

    // keep the low LINE_BITS bits of an incoming line number
    function automatic logic [LINE_BITS-1:0] line_cut(input logic [LINE_IN_W-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return w[LINE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/bmu_cell.sv -----
`default_nettype none
module bmu_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire bmu_pkg::t_cmd   i_cmd,
    input  wire bmu_pkg::t_apply i_apply,
    input  wire bmu_pkg::t_token i_tok,
    output bmu_pkg::t_token      o_tok
);

    logic                          r_valid;
    logic [bmu_pkg::ID_W-1:0]      r_ident;
    logic [bmu_pkg::FILE_W-1:0]    r_file;
    logic [bmu_pkg::LINE_BITS-1:0] r_line;
    logic [bmu_pkg::CNT_W-1:0]     r_rem;
    logic [bmu_pkg::CNT_W-1:0]     r_reload;
    logic                          r_once;
    bmu_pkg::t_token               r_tok;
    bmu_pkg::t_token               n_tok;

    logic w_match;
    logic w_newer;
    logic w_fire;
    logic w_take;
    logic w_drop;

    // entry compares
    assign w_match = r_valid && (r_file == i_cmd.file) && (r_line == i_cmd.line);
    assign w_newer = !i_apply.found || (r_ident > i_apply.fire);
    assign w_fire  = r_valid && i_apply.found && (r_ident == i_apply.fire);
    assign w_take  = i_tok.vld && (i_cmd.op == bmu_pkg::OP_ADD) && !r_valid && !i_tok.done;
    assign w_drop  = i_tok.vld && (i_cmd.op == bmu_pkg::OP_DEL) && r_valid &&
                     (r_ident == i_cmd.target);

    // token update as it passes this entry
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld) begin
            case (i_cmd.op)
                bmu_pkg::OP_TRACE: begin
                    if (w_match && (r_rem == '0) && (!i_tok.done || (r_ident > i_tok.best))) begin
                        n_tok.done = 1'b1;
                        n_tok.best = r_ident;
                    end
                end
                bmu_pkg::OP_ADD: begin
                    if (!r_valid) begin
                        n_tok.done = 1'b1;
                    end
                end
                bmu_pkg::OP_DEL: begin
                    if (w_drop) begin
                        n_tok.done = 1'b1;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    // token stage and valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (w_drop) begin
                r_valid <= 1'b0;
            end else if (i_apply.vld && w_fire && r_once) begin
                r_valid <= 1'b0;
            end
        end
    end

    // entry payload and ignore counter
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ident  <= i_cmd.new_id;
            r_file   <= i_cmd.file;
            r_line   <= i_cmd.line;
            r_rem    <= i_cmd.ign;
            r_reload <= i_cmd.ign;
            r_once   <= i_cmd.tmp;
        end else if (i_apply.vld) begin
            if (w_fire) begin
                r_rem <= r_reload;
            end else if (w_match && (r_rem != '0) && w_newer) begin
                r_rem <= r_rem - bmu_pkg::CNT_W'(1);
            end
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

// ----- sv/breakpoint_match_unit.sv -----
// Breakpoint table of bmu_pkg::ENTRIES entries, one entry per cell in a row; a scan token
// walks the row one cell per cycle. A statement event that must be checked against the
// table goes from acceptance through the row walk, a counter update step and the result
// hand-off before the next item is taken; add and delete skip the counter update; step
// requests, other events, events that meet a pending step or an unknown location, and adds
// with ids exhausted go straight to the result hand-off. One item is worked on at a time; a
// finished result waits in the output register while the next item is taken in. Every item
// returns exactly one result beat.
`default_nettype none
module breakpoint_match_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  [1:0]                  i_opcode,
    input  wire  [1:0]                  i_event_kind,
    input  wire                         i_location_known,
    input  wire  [bmu_pkg::FILE_W-1:0]  i_file_id,
    input  wire  [bmu_pkg::LINE_IN_W-1:0] i_line_number,
    input  wire  [bmu_pkg::ID_W-1:0]    i_target_id,
    input  wire  [bmu_pkg::CNT_W-1:0]   i_ignore_count,
    input  wire                         i_temp_flag,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic                        o_break_hit,
    output logic                        o_hit_source,
    output logic [bmu_pkg::ID_W-1:0]    o_hit_id,
    output logic [bmu_pkg::ID_W-1:0]    o_assigned_id,
    output logic [1:0]                  o_status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]               r_state;
    logic                     r_start;
    logic                     r_step_pending;
    logic [bmu_pkg::ID_W-1:0] r_last_id;
    logic                     r_out_valid;
    bmu_pkg::t_cmd            r_cmd;
    logic                     r_found;
    logic [bmu_pkg::ID_W-1:0] r_fire;
    logic                     r_res_hit;
    logic                     r_res_src;
    logic [bmu_pkg::ID_W-1:0] r_res_hid;
    logic [bmu_pkg::ID_W-1:0] r_res_aid;
    logic [1:0]               r_res_status;
    logic                     r_out_hit;
    logic                     r_out_src;
    logic [bmu_pkg::ID_W-1:0] r_out_hid;
    logic [bmu_pkg::ID_W-1:0] r_out_aid;
    logic [1:0]               r_out_status;

    logic                     w_in_acc;
    logic                     w_stmt;
    logic                     w_scan;
    logic                     w_end;
    logic                     w_load;
    bmu_pkg::t_apply          w_apply;
    bmu_pkg::t_token          w_tok [bmu_pkg::ENTRIES+1];

    // accept decode
    assign w_in_acc = i_in_valid && (r_state == ST_IDLE);
    assign w_stmt   = (i_opcode == bmu_pkg::OP_TRACE) && (i_event_kind == bmu_pkg::EV_STMT);
    assign w_scan   = (w_stmt && !r_step_pending && i_location_known) ||
                      ((i_opcode == bmu_pkg::OP_ADD) && (r_last_id != bmu_pkg::ID_MAX)) ||
                      (i_opcode == bmu_pkg::OP_DEL);
    assign w_end    = w_tok[bmu_pkg::ENTRIES].vld;
    assign w_load   = (r_state == ST_HOLD) && (!r_out_valid || !i_out_stall);

    // row of entry cells
    assign w_tok[0] = '{vld: r_start, done: 1'b0, best: '0};
    assign w_apply  = '{vld: (r_state == ST_APPLY), found: r_found, fire: r_fire};

    for (genvar g = 0; g < bmu_pkg::ENTRIES; g++) begin : g_cell
        bmu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_apply (w_apply),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // sequencer, step flag, id counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_start        <= 1'b0;
            r_step_pending <= 1'b1;
            r_last_id      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_start <= w_in_acc && w_scan;
            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= w_scan ? ST_SCAN : ST_HOLD;
                        if (i_opcode == bmu_pkg::OP_STEP) begin
                            r_step_pending <= 1'b1;
                        end else if (w_stmt) begin
                            r_step_pending <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_end) begin
                        if (r_cmd.op == bmu_pkg::OP_TRACE) begin
                            r_state <= ST_APPLY;
                        end else begin
                            r_state <= ST_HOLD;
                        end
                        if ((r_cmd.op == bmu_pkg::OP_ADD) && w_tok[bmu_pkg::ENTRIES].done) begin
                            r_last_id <= r_cmd.new_id;
                        end
                    end
                end
                ST_APPLY: begin
                    r_state <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (w_load) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // held item, scan outcome and result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd.op     <= i_opcode;
            r_cmd.file   <= i_file_id;
            r_cmd.line   <= bmu_pkg::line_cut(i_line_number);
            r_cmd.target <= i_target_id;
            r_cmd.ign    <= i_ignore_count;
            r_cmd.tmp    <= i_temp_flag;
            r_cmd.new_id <= r_last_id + bmu_pkg::ID_W'(1);
            r_res_hit    <= w_stmt && r_step_pending;
            r_res_src    <= 1'b0;
            r_res_hid    <= '0;
            r_res_aid    <= '0;
            if ((i_opcode == bmu_pkg::OP_ADD) && (r_last_id == bmu_pkg::ID_MAX)) begin
                r_res_status <= bmu_pkg::STAT_EXHAUSTED;
            end else begin
                r_res_status <= bmu_pkg::STAT_OK;
            end
        end
        if ((r_state == ST_SCAN) && w_end) begin
            r_found <= w_tok[bmu_pkg::ENTRIES].done;
            r_fire  <= w_tok[bmu_pkg::ENTRIES].best;
            case (r_cmd.op)
                bmu_pkg::OP_ADD: begin
                    if (w_tok[bmu_pkg::ENTRIES].done) begin
                        r_res_aid <= r_cmd.new_id;
                    end else begin
                        r_res_status <= bmu_pkg::STAT_FULL;
                    end
                end
                bmu_pkg::OP_DEL: begin
                    if (!w_tok[bmu_pkg::ENTRIES].done) begin
                        r_res_status <= bmu_pkg::STAT_UNKNOWN;
                    end
                end
                default: begin
                    r_res_status <= bmu_pkg::STAT_OK;
                end
            endcase
        end
        if (r_state == ST_APPLY) begin
            r_res_hit <= r_found;
            r_res_src <= r_found;
            r_res_hid <= r_found ? r_fire : '0;
        end
        if (w_load) begin
            r_out_hit    <= r_res_hit;
            r_out_src    <= r_res_src;
            r_out_hid    <= r_res_hid;
            r_out_aid    <= r_res_aid;
            r_out_status <= r_res_status;
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_break_hit   = r_out_hit;
    assign o_hit_source  = r_out_src;
    assign o_hit_id      = r_out_hid;
    assign o_assigned_id = r_out_aid;
    assign o_status      = r_out_status;

    // checks
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |-> (r_state == ST_SCAN))
        else $error("scan token left the row outside a scan");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && w_end) |=> ((r_state == ST_APPLY) || (r_state == ST_HOLD)))
        else $error("scan did not finish when token left the row");

    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_last_id != $past(r_last_id)))
            |-> (r_last_id == $past(r_last_id) + bmu_pkg::ID_W'(1)))
        else $error("breakpoint id counter moved by other than one");

endmodule
`default_nettype wire
